// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expects a signal named clock in the using scope; BSPT_ASSERT also needs reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define BSPT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define BSPT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/bspt_pkg.sv
package bspt_pkg;

   localparam int NUM_BUCKETS = 256;
   localparam int BUCKET_W    = 8;
   localparam int NUM_SLOTS   = 32;
   localparam int SLOT_W      = 5;
   localparam int STORE_AW    = BUCKET_W + SLOT_W;

   localparam logic [31:0] SEED_RESET = 32'h9e3779b9;
   localparam logic [31:0] MIX_A      = 32'h85ebca6b;
   localparam logic [31:0] MIX_B      = 32'hc2b2ae35;

   localparam logic [3:0] LOG2_MAX   = 4'd8;
   localparam logic [3:0] LOG2_RESET = 4'd8;
   localparam logic [5:0] SIZE_MAX   = 6'd32;
   localparam logic [5:0] SIZE_RESET = 6'd8;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] CSR_SEED = 2'd0;
   localparam logic [1:0] CSR_LOG2 = 2'd1;
   localparam logic [1:0] CSR_SIZE = 2'd2;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_DEREF = 2'd1;
   localparam logic [1:0] REQ_FREE  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Step controls from the sequencer to the shared hash multiplier.
   typedef struct packed {
      logic first;
      logic second;
   } hash_ctrl_type;

endpackage

// File: rtl/bspt_if.sv
interface bspt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [31:0] key;
   logic signed [31:0] value;
   logic [4:0]         slot_ptr;

   modport source (output valid, req_type, key, value, slot_ptr, input ready);
   modport sink (input valid, req_type, key, value, slot_ptr, output ready);
endinterface

interface bspt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [4:0]         slot_out;
   logic signed [31:0] read_value;
   logic [7:0]         bucket_index;

   modport source (output valid, status, slot_out, read_value, bucket_index, input ready);
   modport sink (input valid, status, slot_out, read_value, bucket_index, output ready);
endinterface

// File: rtl/bucketed_slot_pointer_table.sv
// Bucketed slot pointer table: a small allocator handing out slot numbers
// within a bucket chosen by a seeded hash of the request key.
// Requests arrive on req_ch (allocate, dereference, free) and each produces
// exactly one transaction on rsp_ch carrying status, slot, read value and the
// bucket index. The hash seed, bucket count log2 and slots-per-bucket registers
// sit at byte addresses 0, 4 and 8 of the APB port and should be written while idle.
// A request passes through four steps: the accept step runs the first hash
// multiply, ST_MUL2 the second multiply on the same multiplier, ST_LOOKUP reads
// the bucket mask and value memories, and ST_FINISH updates them and loads the
// response register. A new request is accepted only once the block is back in
// ST_IDLE, so it works on one request at a time.
// If rsp_ch stalls, the finished response waits in its register and the block
// holds its last step until the register frees, so nothing is lost.
// Reset restores the register defaults and marks every bucket mask as all
// free at once; freed slots always read as zero, so the value memory needs no
// clearing pass and the block is ready in the first cycle after reset.
module bucketed_slot_pointer_table
   import bspt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bspt_req_if.sink    req_ch,
   bspt_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL2   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]  state_ff, state_in;

   logic [31:0] seed_ff;
   logic [3:0]  log2_ff;
   logic [5:0]  size_ff;
   logic        csr_write;

   logic [1:0]  type_ff;
   logic [31:0] key_ff;
   logic [31:0] value_ff;
   logic [4:0]  ptr_ff;

   hash_ctrl_type hash_ctrl;
   logic [31:0]   hash;

   logic [3:0]          log2_eff;
   logic [8:0]          bucket_span;
   logic [BUCKET_W-1:0] bucket_sel;
   logic [BUCKET_W-1:0] bucket_ff;

   logic [31:0]      mask_ram [NUM_BUCKETS];
   logic [31:0]      store_ram [NUM_BUCKETS * NUM_SLOTS];
   logic [NUM_BUCKETS-1:0] mask_valid_ff, mask_valid_in;
   logic [31:0]      mask_rd_ff;
   logic             mask_vld_rd_ff;
   logic [31:0]      store_rd_ff;

   logic [5:0]        size_eff;
   logic [32:0]       size_span;
   logic [31:0]       size_mask;
   logic [31:0]       mask_cur;
   logic [31:0]       avail;
   logic [SLOT_W-1:0] alloc_slot;
   logic              ptr_beyond;

   logic              finish;
   logic              mask_we;
   logic [31:0]       mask_wdata;
   logic              store_we;
   logic [1:0]        status_res;
   logic [SLOT_W-1:0] slot_res;
   logic [31:0]       read_res;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [31:0]       read_ff;
   logic [7:0]        bucket_out_ff;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
         log2_ff <= LOG2_RESET;
         size_ff <= SIZE_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            CSR_SEED: seed_ff <= pwdata;
            CSR_LOG2: log2_ff <= pwdata[3:0];
            CSR_SIZE: size_ff <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_SEED: prdata = seed_ff;
         CSR_LOG2: prdata = {28'd0, log2_ff};
         CSR_SIZE: prdata = {26'd0, size_ff};
         default:  prdata = 32'd0;
      endcase
   end

   // Sequencer.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign finish       = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_ch.valid) state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_FINISH;
         ST_FINISH: if (finish) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         type_ff  <= req_ch.req_type;
         key_ff   <= $unsigned(req_ch.key);
         value_ff <= $unsigned(req_ch.value);
         ptr_ff   <= req_ch.slot_ptr;
      end
   end

   // The first round works straight from the incoming transaction.
   assign hash_ctrl.first  = req_ch.valid && req_ch.ready;
   assign hash_ctrl.second = (state_ff == ST_MUL2);

   bspt_hash_unit u_hash (
      .clock (clock),
      .ctrl  (hash_ctrl),
      .key   ((state_ff == ST_IDLE) ? $unsigned(req_ch.key) : key_ff),
      .seed  (seed_ff),
      .hash  (hash)
   );

   // Bucket selection.
   assign log2_eff    = (log2_ff > LOG2_MAX) ? LOG2_MAX : log2_ff;
   assign bucket_span = (9'd1 << log2_eff) - 9'd1;
   assign bucket_sel  = hash[BUCKET_W-1:0] & bucket_span[BUCKET_W-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP) begin
         bucket_ff      <= bucket_sel;
         mask_rd_ff     <= mask_ram[bucket_sel];
         mask_vld_rd_ff <= mask_valid_ff[bucket_sel];
         store_rd_ff    <= store_ram[{bucket_sel, ptr_ff}];
      end
   end

   // Request evaluation.
   assign size_eff   = (size_ff > SIZE_MAX) ? SIZE_MAX : size_ff;
   assign size_span  = (33'd1 << size_eff) - 33'd1;
   assign size_mask  = size_span[31:0];
   assign mask_cur   = mask_vld_rd_ff ? mask_rd_ff : '1;
   assign avail      = mask_cur & size_mask;
   assign ptr_beyond = ({1'b0, ptr_ff} >= size_eff);

   always_comb begin
      alloc_slot = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (avail[i]) alloc_slot = SLOT_W'(i);
      end
   end

   // A slot whose free bit is set may still hold an old value, since freeing
   // does not clear it. Dereference masks with the free bit instead of writing
   // zeros, so the value memory never needs clearing.
   always_comb begin
      status_res = STATUS_OK;
      slot_res   = '0;
      read_res   = '0;
      mask_we    = 1'b0;
      mask_wdata = mask_cur;
      store_we   = 1'b0;
      case (type_ff)
         REQ_ALLOC: begin
            if (avail == 32'd0) begin
               status_res = STATUS_FULL;
            end else begin
               slot_res   = alloc_slot;
               mask_we    = 1'b1;
               mask_wdata = mask_cur & ~(32'd1 << alloc_slot);
               store_we   = 1'b1;
            end
         end
         REQ_DEREF: begin
            if (ptr_beyond) begin
               status_res = STATUS_RANGE;
            end else if (!mask_cur[ptr_ff]) begin
               read_res = store_rd_ff;
            end
         end
         REQ_FREE: begin
            if (ptr_beyond) begin
               status_res = STATUS_RANGE;
            end else begin
               mask_we    = 1'b1;
               mask_wdata = mask_cur | (32'd1 << ptr_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (finish && mask_we) begin
         mask_ram[bucket_ff] <= mask_wdata;
      end
      if (finish && store_we) begin
         store_ram[{bucket_ff, alloc_slot}] <= value_ff;
      end
   end

   always_comb begin
      mask_valid_in = mask_valid_ff;
      if (finish && mask_we) begin
         mask_valid_in[bucket_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_valid_ff <= '0;
      end else begin
         mask_valid_ff <= mask_valid_in;
      end
   end

   // Response register.
   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff     <= status_res;
         slot_ff       <= slot_res;
         read_ff       <= read_res;
         bucket_out_ff <= bucket_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.slot_out     = slot_ff;
   assign rsp_ch.read_value   = $signed(read_ff);
   assign rsp_ch.bucket_index = bucket_out_ff;

endmodule

// File: rtl/bspt_hash_unit.sv
module bspt_hash_unit
   import bspt_pkg::*;
(
   input  logic          clock,
   input  hash_ctrl_type ctrl,
   input  logic [31:0]   key,
   input  logic [31:0]   seed,
   output logic [31:0]   hash
);

   logic [31:0] prod_ff;
   logic [31:0] prod_in;
   logic [31:0] seeded;
   logic [31:0] operand;
   logic [31:0] factor;
   logic [63:0] full;

   assign seeded = key ^ seed;

   // One multiplier serves both mixing rounds; the sequencer picks the round.
   always_comb begin
      if (ctrl.first) begin
         operand = seeded ^ (seeded >> 16);
         factor  = MIX_A;
      end else begin
         operand = prod_ff ^ (prod_ff >> 13);
         factor  = MIX_B;
      end
      full = operand * factor;
      prod_in = full[31:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.first || ctrl.second) begin
         prod_ff <= prod_in;
      end
   end

   assign hash = prod_ff ^ (prod_ff >> 16);

endmodule

// File: rtl/bspt_checker.sv
`include "assert_macros.svh"

module bspt_checker
   import bspt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  status,
   input logic [4:0]  slot_out,
   input logic [31:0] read_value
);

   // A held response must stay until the sink takes it.
   `BSPT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // The block works on one transaction at a time.
   `BSPT_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "accepted back to back")

   `BSPT_ASSERT(a_status_code, rsp_valid |-> (status == STATUS_OK || status == STATUS_FULL || status == STATUS_RANGE), "undefined status code")

   // Only a granted allocate or a good dereference carries data.
   `BSPT_ASSERT(a_error_zero, rsp_valid && status != STATUS_OK |-> slot_out == 5'd0 && read_value == 32'd0, "error response carries data")

endmodule

bind bucketed_slot_pointer_table bspt_checker u_bspt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .status     (rsp_ch.status),
   .slot_out   (rsp_ch.slot_out),
   .read_value (rsp_ch.read_value)
);
